// ----- rtl/bqen_pkg.sv -----
// Shared constants, types and helper functions of the bit-quad Euler number block.
package bqen_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int SIZE_W  = 11;
	localparam int CNT_W   = 21;
	localparam int EULER_W = 19;
	localparam int DIFF_W  = CNT_W + 3;
	localparam int QUO_W   = DIFF_W - 2;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

	localparam int EULER_HI = (1 << (EULER_W - 1)) - 1;
	localparam int EULER_LO = -(1 << (EULER_W - 1));

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic one;
		logic three;
		logic diag;
	} quad_class_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic             data;
	} line_wr_t;

	// a b on the top row, c d on the bottom row
	function automatic quad_class_t classify(logic a, logic b, logic c, logic d);
		quad_class_t qc;
		logic [2:0]  n;
		n        = 3'(a) + 3'(b) + 3'(c) + 3'(d);
		qc.one   = (n == 3'd1);
		qc.three = (n == 3'd3);
		qc.diag  = (a & d & ~b & ~c) | (b & c & ~a & ~d);
		return qc;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] cnt, logic [2:0] inc);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(cnt) + (CNT_W + 1)'(inc);
		return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	endfunction

	function automatic logic [WDIM_W-1:0] clamp_width(logic [SIZE_W-1:0] v);
		if (v == '0)
			return WDIM_W'(1);
		else if (32'(v) > MAX_WIDTH)
			return WDIM_W'(MAX_WIDTH);
		else
			return WDIM_W'(v);
	endfunction

	function automatic logic [HDIM_W-1:0] clamp_height(logic [SIZE_W-1:0] v);
		if (v == '0)
			return HDIM_W'(1);
		else if (32'(v) > MAX_HEIGHT)
			return HDIM_W'(MAX_HEIGHT);
		else
			return HDIM_W'(v);
	endfunction

	// (q1 - q3 - 2*qd) / 4, truncated toward zero, saturated to the output range
	function automatic logic signed [EULER_W-1:0] euler_of(logic [CNT_W-1:0] q1,
			logic [CNT_W-1:0] q3, logic [CNT_W-1:0] qd);
		logic signed [DIFF_W-1:0] diff;
		logic signed [DIFF_W-1:0] adj;
		logic signed [QUO_W-1:0]  quo;
		diff = $signed({3'b000, q1}) - $signed({3'b000, q3}) - $signed({2'b00, qd, 1'b0});
		adj  = diff[DIFF_W-1] ? diff + DIFF_W'(3) : diff;
		quo  = adj[DIFF_W-1:2];
		if (quo > QUO_W'(EULER_HI))
			return EULER_W'(EULER_HI);
		else if (quo < QUO_W'(EULER_LO))
			return EULER_W'(EULER_LO);
		else
			return quo[EULER_W-1:0];
	endfunction

endpackage

// ----- rtl/bqen_if.sv -----
// Handshake channel interfaces: pixel stream, result stream and configuration writes.
interface bqen_pix_if;
	logic valid;
	logic ready;
	logic object_pixel;

	modport source(output valid, output object_pixel, input ready);
	modport sink(input valid, input object_pixel, output ready);
endinterface

interface bqen_res_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [bqen_pkg::EULER_W-1:0]      euler_number;
	logic        [bqen_pkg::CNT_W-1:0]        quad_one_count;
	logic        [bqen_pkg::CNT_W-1:0]        quad_three_count;
	logic        [bqen_pkg::CNT_W-1:0]        quad_diag_count;

	modport source(output valid, output euler_number, output quad_one_count,
		output quad_three_count, output quad_diag_count, input ready);
	modport sink(input valid, input euler_number, input quad_one_count,
		input quad_three_count, input quad_diag_count, output ready);
endinterface

interface bqen_cfg_if;
	logic                          valid;
	logic                          ready;
	bqen_pkg::cfg_reg_t            index;
	logic [bqen_pkg::SIZE_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/bqen_line_buf.sv -----
// One-row line buffer with registered read and write-to-read bypass.
module bqen_line_buf (
	input  logic                         clk,
	input  logic [bqen_pkg::COL_W-1:0]   rd_addr,
	input  bqen_pkg::line_wr_t           wr,
	output logic                         rd_data
);

	logic mem [bqen_pkg::MAX_WIDTH];
	logic rd_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
	end

	// forward the bit being written when the next read hits the same column
	always_ff @(posedge clk) begin
		if (wr.en && wr.addr == rd_addr)
			rd_q <= wr.data;
		else
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/bit_quad_euler_number.sv -----
// Bit-quad Euler number (8-connected) of a streamed binary frame: top level.
//
// Pixels enter in raster order, one per cycle, and a pixel is taken in the cycle it is offered
// unless the result path is full. Each pixel closes up to four 2x2 quads of the zero-padded
// frame; the quad counts update in the cycle of the transfer. After the last pixel of a frame
// one result leaves: a first register latches the final counts, and the output register then
// takes the Euler number formed from them once it is free. Pixel ready drops
// only while two finished results are waiting, which happens when the consumer holds back one
// result until the next frame has also ended. The row above comes from a line buffer of
// MAX_WIDTH bits whose read for the next column is issued with each transfer; reads on the first
// row are masked, so no reset sweep of the buffer is needed. Frame size writes (0 acts as 1, values
// above the maximum act as the maximum) belong between frames.
module bit_quad_euler_number (
	input  logic               clk,
	input  logic               arst_n,
	bqen_cfg_if.sink           cfg,
	bqen_pix_if.sink           pixel,
	bqen_res_if.source         result
);

	logic [bqen_pkg::WDIM_W-1:0] width_q;
	logic [bqen_pkg::HDIM_W-1:0] height_q;
	logic [bqen_pkg::COL_W-1:0]  col_q;
	logic [bqen_pkg::ROW_W-1:0]  row_q;
	logic                        left_q;
	logic                        uleft_q;
	logic [bqen_pkg::CNT_W-1:0]  one_q;
	logic [bqen_pkg::CNT_W-1:0]  three_q;
	logic [bqen_pkg::CNT_W-1:0]  diag_q;

	logic                        res_valid_s1;
	logic [bqen_pkg::CNT_W-1:0]  res_one_s1;
	logic [bqen_pkg::CNT_W-1:0]  res_three_s1;
	logic [bqen_pkg::CNT_W-1:0]  res_diag_s1;

	logic                                out_valid_q;
	logic signed [bqen_pkg::EULER_W-1:0] out_euler_q;
	logic [bqen_pkg::CNT_W-1:0]          out_one_q;
	logic [bqen_pkg::CNT_W-1:0]          out_three_q;
	logic [bqen_pkg::CNT_W-1:0]          out_diag_q;

	logic                        accept;
	logic                        p;
	logic                        up_raw;
	logic                        up;
	logic                        ul;
	logic                        lf;
	logic                        first_col;
	logic                        last_col;
	logic                        last_row;
	logic                        frame_end;
	logic                        out_free;
	logic [bqen_pkg::COL_W-1:0]  col_next;
	logic [bqen_pkg::COL_W-1:0]  rd_addr;
	bqen_pkg::line_wr_t          line_wr;
	bqen_pkg::quad_class_t       qc_main;
	bqen_pkg::quad_class_t       qc_right;
	bqen_pkg::quad_class_t       qc_below;
	bqen_pkg::quad_class_t       qc_corner;
	logic [2:0]                  inc_one;
	logic [2:0]                  inc_three;
	logic [2:0]                  inc_diag;
	logic [bqen_pkg::CNT_W-1:0]  one_next;
	logic [bqen_pkg::CNT_W-1:0]  three_next;
	logic [bqen_pkg::CNT_W-1:0]  diag_next;

	assign cfg.ready   = 1'b1;
	assign pixel.ready = !(res_valid_s1 && out_valid_q);
	assign accept      = pixel.valid && pixel.ready;
	assign p           = pixel.object_pixel;

	assign first_col = (col_q == '0);
	assign last_col  = (bqen_pkg::WDIM_W'(col_q) + bqen_pkg::WDIM_W'(1)) >= width_q;
	assign last_row  = (bqen_pkg::HDIM_W'(row_q) + bqen_pkg::HDIM_W'(1)) >= height_q;
	assign frame_end = last_col && last_row;

	// zero border: no row above on the first row, no left neighbors on the first column
	assign up = up_raw && (row_q != '0);
	assign ul = uleft_q && !first_col;
	assign lf = left_q && !first_col;

	assign col_next = last_col ? '0 : col_q + bqen_pkg::COL_W'(1);
	assign rd_addr  = accept ? col_next : col_q;

	assign line_wr.en   = accept;
	assign line_wr.addr = col_q;
	assign line_wr.data = p;

	bqen_line_buf u_line_buf (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr      (line_wr),
		.rd_data (up_raw)
	);

	// quads off the right edge or below the bottom edge are gated to all zeros when not closing
	assign qc_main   = bqen_pkg::classify(ul, up, lf, p);
	assign qc_right  = bqen_pkg::classify(up & last_col, 1'b0, p & last_col, 1'b0);
	assign qc_below  = bqen_pkg::classify(lf & last_row, p & last_row, 1'b0, 1'b0);
	assign qc_corner = bqen_pkg::classify(p & frame_end, 1'b0, 1'b0, 1'b0);

	assign inc_one   = 3'(qc_main.one) + 3'(qc_right.one) + 3'(qc_below.one)
		+ 3'(qc_corner.one);
	assign inc_three = 3'(qc_main.three) + 3'(qc_right.three) + 3'(qc_below.three)
		+ 3'(qc_corner.three);
	assign inc_diag  = 3'(qc_main.diag) + 3'(qc_right.diag) + 3'(qc_below.diag)
		+ 3'(qc_corner.diag);

	assign one_next   = bqen_pkg::sat_add(one_q, inc_one);
	assign three_next = bqen_pkg::sat_add(three_q, inc_three);
	assign diag_next  = bqen_pkg::sat_add(diag_q, inc_diag);

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= bqen_pkg::clamp_width(bqen_pkg::SIZE_W'(1024));
			height_q     <= bqen_pkg::clamp_height(bqen_pkg::SIZE_W'(1024));
			col_q        <= '0;
			row_q        <= '0;
			left_q       <= 1'b0;
			uleft_q      <= 1'b0;
			one_q        <= '0;
			three_q      <= '0;
			diag_q       <= '0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					bqen_pkg::REG_IMAGE_WIDTH:  width_q  <= bqen_pkg::clamp_width(cfg.data);
					bqen_pkg::REG_IMAGE_HEIGHT: height_q <= bqen_pkg::clamp_height(cfg.data);
					default: ;
				endcase
			end

			if (accept) begin
				col_q <= col_next;
				if (frame_end) begin
					row_q   <= '0;
					left_q  <= 1'b0;
					uleft_q <= 1'b0;
					one_q   <= '0;
					three_q <= '0;
					diag_q  <= '0;
				end else begin
					if (last_col)
						row_q <= row_q + bqen_pkg::ROW_W'(1);
					left_q  <= p;
					uleft_q <= up;
					one_q   <= one_next;
					three_q <= three_next;
					diag_q  <= diag_next;
				end
			end

			// drain the latched counts into the output stage, refill on a frame end
			if (accept && frame_end)
				res_valid_s1 <= 1'b1;
			else if (out_free)
				res_valid_s1 <= 1'b0;

			if (out_free)
				out_valid_q <= res_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			res_one_s1   <= one_next;
			res_three_s1 <= three_next;
			res_diag_s1  <= diag_next;
		end
		if (out_free && res_valid_s1) begin
			out_euler_q <= bqen_pkg::euler_of(res_one_s1, res_three_s1, res_diag_s1);
			out_one_q   <= res_one_s1;
			out_three_q <= res_three_s1;
			out_diag_q  <= res_diag_s1;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.euler_number     = out_euler_q;
	assign result.quad_one_count   = out_one_q;
	assign result.quad_three_count = out_three_q;
	assign result.quad_diag_count  = out_diag_q;

endmodule
